// File: rtl/core/assert_macros.svh
// Assertion helpers shared by the RTL that checks its own behavior.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Plain property, sampled on the rising clock edge, off while reset is low.
`define SCPR_ASSERT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Same-cycle implication from an enabling condition.
`define SCPR_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

`endif

// File: rtl/core/scpr_pkg.sv
`default_nettype none

package scpr_pkg;

  // Fixed widths of the register and the result fields.
  localparam int unsigned FRAME_COUNT_W   = 3;
  localparam logic [FRAME_COUNT_W-1:0] FRAME_COUNT_RST = 3'd4;
  localparam int unsigned FAULT_W         = 16;
  localparam int unsigned SLOT_OUT_W      = 2;

  // Commands broadcast from the sequencer to every cell.
  typedef struct packed {
    logic step;    // sweep cycle: the cell under the hand clears a set bit
    logic commit;  // the cell under the hand with a clear bit takes the page
    logic shift;   // the hand moves one cell along the ring
    logic rehome;  // the hand is put back on cell 0
    logic hit;     // the selected matching cell sets its reference bit
  } cell_ctl_t;

  // Status reported by each cell.
  typedef struct packed {
    logic match;      // holds the looked-up page and is in use
    logic ref_set;    // hand is here and the reference bit is set
    logic place_rdy;  // hand is here and the reference bit is clear
    logic old_valid;  // the cell holds a valid page
    logic tok;        // hand is here
  } cell_stat_t;

endpackage

`default_nettype wire

// File: rtl/core/scpr_req_if.sv
`default_nettype none

interface scpr_req_if #(
  parameter int unsigned PAGE_BITS = 16
);
  logic                 valid;
  logic                 ready;
  logic [PAGE_BITS-1:0] page_number;
  logic                 last_reference;

  modport source (output valid, page_number, last_reference, input ready);
  modport sink   (input valid, page_number, last_reference, output ready);
endinterface

`default_nettype wire

// File: rtl/core/scpr_rsp_if.sv
`default_nettype none

interface scpr_rsp_if #(
  parameter int unsigned PAGE_BITS = 16
);
  logic                                valid;
  logic                                ready;
  logic                                fault;
  logic [scpr_pkg::SLOT_OUT_W-1:0]     frame_slot;
  logic                                evicted_valid;
  logic [PAGE_BITS-1:0]                evicted_page;
  logic [scpr_pkg::FAULT_W-1:0]        fault_total;
  logic                                last_result;

  modport source (output valid, fault, frame_slot, evicted_valid, evicted_page,
                  fault_total, last_result, input ready);
  modport sink   (input valid, fault, frame_slot, evicted_valid, evicted_page,
                  fault_total, last_result, output ready);
endinterface

`default_nettype wire

// File: rtl/core/scpr_cell.sv
`default_nettype none

module scpr_cell #(
  parameter int unsigned PAGE_BITS = 16,
  parameter bit          TOK_RESET = 1'b0
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 in_use_i,
  input  wire logic [PAGE_BITS-1:0] key_i,
  input  wire logic                 hit_sel_i,
  input  wire logic                 tok_i,
  input  scpr_pkg::cell_ctl_t       ctl_i,
  output scpr_pkg::cell_stat_t      stat_o,
  output logic [PAGE_BITS-1:0]      page_o
);
  import scpr_pkg::*;

  logic [PAGE_BITS-1:0] page_q;
  logic                 valid_q;
  logic                 ref_q;
  logic                 tok_q;
  logic                 place;

  // The cell under the hand whose bit is clear takes the new page.
  assign place = ctl_i.commit & tok_q & ~ref_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      ref_q   <= 1'b0;
      tok_q   <= TOK_RESET;
    end else begin
      if (place) begin
        valid_q <= 1'b1;
        ref_q   <= 1'b0;
      end else if (ctl_i.step && tok_q && ref_q) begin
        ref_q <= 1'b0;
      end else if (ctl_i.hit && hit_sel_i) begin
        ref_q <= 1'b1;
      end
      if (ctl_i.shift || ctl_i.rehome) begin
        tok_q <= tok_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (place) begin
      page_q <= key_i;
    end
  end

  assign stat_o.match     = valid_q & in_use_i & (page_q == key_i);
  assign stat_o.ref_set   = tok_q & ref_q;
  assign stat_o.place_rdy = tok_q & ~ref_q;
  assign stat_o.old_valid = valid_q;
  assign stat_o.tok       = tok_q;
  assign page_o           = page_q;

endmodule

`default_nettype wire

// File: rtl/core/second_chance_page_replacement.sv
// Second-chance (clock) page replacement over a small row of frames.
// A page reference arrives as one transaction on req_i (page number and an
// end-of-string mark); exactly one result transaction leaves on rsp_o for
// each reference, in order: fault flag, frame slot, evicted page if any,
// the saturating fault total and the echoed end-of-string mark.
// The frame count register is written through cfg_we_i/cfg_wdata_i while the
// block is idle, a rule for the user that the block does not enforce; a value
// of zero acts as one, values above MAX_FRAMES act as MAX_FRAMES.
// Steps: idle takes the reference and look-up checks for a hit, which loads
// the result register and returns to idle; on a miss the sweep state clears
// the set reference bits the hand meets until it reaches a frame with a clear
// bit, which takes the page while the result register is loaded, and returns
// to idle for the next reference.
// The hand is a token that walks the ring of frame cells one cell a cycle
// in the sweep, unless a placement waits on the output register. The result
// sits in an output register, so the next reference is taken while an
// earlier result still waits. If the receiver stalls and a new result is
// ready to be written, the block holds in place until the output register
// frees up. Reset empties all frames, clears reference bits, puts the hand on
// frame 0, zeroes the fault total and sets the frame count to four.
`default_nettype none

`include "assert_macros.svh"

module second_chance_page_replacement #(
  parameter int unsigned MAX_FRAMES = 4,
  parameter int unsigned PAGE_BITS  = 16
) (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  input  wire logic                                cfg_we_i,
  input  wire logic [scpr_pkg::FRAME_COUNT_W-1:0]  cfg_wdata_i,
  scpr_req_if.sink                                 req_i,
  scpr_rsp_if.source                               rsp_o
);
  import scpr_pkg::*;

  localparam int unsigned SLOT_W = (MAX_FRAMES > 1) ? $clog2(MAX_FRAMES) : 1;

  // Sequencer states.
  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_LOOK  = 2'd1;
  localparam logic [1:0] S_SWEEP = 2'd2;

  logic [1:0]               state_q, state_d;
  logic [FRAME_COUNT_W-1:0] frame_count_q;
  logic [PAGE_BITS-1:0]     key_q;
  logic                     last_q;
  logic [FAULT_W-1:0]       fault_q, fault_d, fault_inc;

  // Output register.
  logic                     out_valid_q;
  logic                     out_fault_q;
  logic [SLOT_OUT_W-1:0]    out_slot_q;
  logic                     out_ev_valid_q;
  logic [PAGE_BITS-1:0]     out_ev_page_q;
  logic [FAULT_W-1:0]       out_total_q;
  logic                     out_last_q;
  logic                     out_free;

  // Cell row.
  logic [MAX_FRAMES-1:0]    in_use;
  logic [MAX_FRAMES-1:0]    tok_in;
  logic [MAX_FRAMES-1:0]    tok;
  logic [MAX_FRAMES-1:0]    match;
  logic [MAX_FRAMES-1:0]    hit_sel;
  logic [MAX_FRAMES-1:0]    place_sel;
  logic [MAX_FRAMES-1:0]    wrap;
  cell_stat_t               stat [MAX_FRAMES];
  logic [PAGE_BITS-1:0]     cell_page [MAX_FRAMES];
  cell_ctl_t                ctl;

  logic                     any_match, any_ref, any_place, oob;
  logic [SLOT_W-1:0]        hit_slot, place_slot;
  logic                     ev_valid;
  logic [PAGE_BITS-1:0]     ev_page;
  logic                     hit_commit;
  logic [SLOT_W+1:0]        hit_slot_ext, place_slot_ext;
  logic                     place_ok;

  // ---------------------------------------------------------------------------
  // Frame count register. A frame is searched and swept only while it is in
  // use; frame 0 is always in use.
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frame_count_q <= FRAME_COUNT_RST;
    end else if (cfg_we_i) begin
      frame_count_q <= cfg_wdata_i;
    end
  end

  // ---------------------------------------------------------------------------
  // The row of frame cells. The hand token passes to the next cell in use, or
  // wraps to cell 0 after the last one in use.
  // ---------------------------------------------------------------------------
  for (genvar i = 0; i < MAX_FRAMES; i++) begin : g_cell
    assign in_use[i] = (i == 0) || (int'(frame_count_q) > i);
    assign match[i]  = stat[i].match;
    assign tok[i]    = stat[i].tok;

    if (i == MAX_FRAMES - 1) begin : g_last
      assign wrap[i] = tok[i];
    end else begin : g_mid
      assign wrap[i] = tok[i] & ~in_use[i+1];
    end

    if (i == 0) begin : g_first
      assign tok_in[i] = ctl.rehome | (|wrap);
    end else begin : g_next
      assign tok_in[i] = ~ctl.rehome & tok[i-1] & in_use[i];
    end

    scpr_cell #(
      .PAGE_BITS (PAGE_BITS),
      .TOK_RESET (i == 0)
    ) u_cell (
      .clk_i     (clk_i),
      .rst_ni    (rst_ni),
      .in_use_i  (in_use[i]),
      .key_i     (key_q),
      .hit_sel_i (hit_sel[i]),
      .tok_i     (tok_in[i]),
      .ctl_i     (ctl),
      .stat_o    (stat[i]),
      .page_o    (cell_page[i])
    );
  end

  // Lowest-numbered match wins when a stale duplicate sits in a higher frame.
  always_comb begin
    logic seen;
    seen = 1'b0;
    for (int i = 0; i < MAX_FRAMES; i++) begin
      hit_sel[i] = match[i] & ~seen;
      seen       = seen | match[i];
    end
  end

  always_comb begin
    any_match  = 1'b0;
    any_ref    = 1'b0;
    any_place  = 1'b0;
    oob        = 1'b0;
    hit_slot   = '0;
    place_slot = '0;
    ev_valid   = 1'b0;
    ev_page    = '0;
    for (int i = 0; i < MAX_FRAMES; i++) begin
      place_sel[i] = stat[i].place_rdy;
      any_match    = any_match | match[i];
      any_ref      = any_ref | stat[i].ref_set;
      any_place    = any_place | stat[i].place_rdy;
      oob          = oob | (tok[i] & ~in_use[i]);
      if (hit_sel[i]) begin
        hit_slot = hit_slot | SLOT_W'(i);
      end
      if (stat[i].place_rdy) begin
        place_slot = place_slot | SLOT_W'(i);
        ev_valid   = ev_valid | stat[i].old_valid;
        if (stat[i].old_valid) begin
          ev_page = ev_page | cell_page[i];
        end
      end
    end
  end

  assign hit_slot_ext   = {2'b00, hit_slot};
  assign place_slot_ext = {2'b00, place_slot};

  // ---------------------------------------------------------------------------
  // Sequencer.
  // ---------------------------------------------------------------------------
  assign out_free   = ~out_valid_q | rsp_o.ready;
  assign req_i.ready = (state_q == S_IDLE);
  assign hit_commit = (state_q == S_LOOK) & any_match & out_free;
  assign fault_inc  = (fault_q == '1) ? fault_q : fault_q + FAULT_W'(1);

  always_comb begin
    state_d    = state_q;
    fault_d    = fault_q;
    ctl        = '0;
    case (state_q)
      S_IDLE: begin
        if (req_i.valid) begin
          state_d = S_LOOK;
        end
      end
      S_LOOK: begin
        if (any_match) begin
          ctl.hit = out_free;
          if (out_free) begin
            state_d = S_IDLE;
          end
        end else begin
          // A hand left beyond a shrunken frame count starts over at frame 0.
          ctl.rehome = oob;
          state_d    = S_SWEEP;
        end
      end
      S_SWEEP: begin
        ctl.step   = 1'b1;
        ctl.commit = any_place & out_free;
        ctl.shift  = any_ref | (any_place & out_free);
        if (any_place && out_free) begin
          fault_d = fault_inc;
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      fault_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      fault_q <= fault_d;
      if (hit_commit || ctl.commit) begin
        out_valid_q <= 1'b1;
      end else if (rsp_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.valid && req_i.ready) begin
      key_q  <= req_i.page_number;
      last_q <= req_i.last_reference;
    end
    if (hit_commit) begin
      out_fault_q    <= 1'b0;
      out_slot_q     <= hit_slot_ext[SLOT_OUT_W-1:0];
      out_ev_valid_q <= 1'b0;
      out_ev_page_q  <= '0;
      out_total_q    <= fault_q;
      out_last_q     <= last_q;
    end else if (ctl.commit) begin
      out_fault_q    <= 1'b1;
      out_slot_q     <= place_slot_ext[SLOT_OUT_W-1:0];
      out_ev_valid_q <= ev_valid;
      out_ev_page_q  <= ev_page;
      out_total_q    <= fault_inc;
      out_last_q     <= last_q;
    end
  end

  assign rsp_o.valid         = out_valid_q;
  assign rsp_o.fault         = out_fault_q;
  assign rsp_o.frame_slot    = out_slot_q;
  assign rsp_o.evicted_valid = out_ev_valid_q;
  assign rsp_o.evicted_page  = out_ev_page_q;
  assign rsp_o.fault_total   = out_total_q;
  assign rsp_o.last_result   = out_last_q;

  // ---------------------------------------------------------------------------
  // Assertions.
  // ---------------------------------------------------------------------------
  // A placement goes into exactly one frame, and only one that is in use.
  assign place_ok = $onehot(place_sel) && ((place_sel & ~in_use) == '0);

  // The hand is always in exactly one cell.
  `SCPR_ASSERT(a_hand_onehot, clk_i, rst_ni, $onehot(tok), "hand token is not one-hot")
  // A hit sets the bit of exactly one frame.
  `SCPR_ASSERT_IMP(a_hit_single, clk_i, rst_ni, hit_commit, $onehot(hit_sel), "hit not unique")
  // A page is only placed into a single frame that is in use.
  `SCPR_ASSERT_IMP(a_place_single, clk_i, rst_ni, ctl.commit, place_ok, "bad placement frame")
  // The fault total never goes backwards.
  `SCPR_ASSERT(a_fault_mono, clk_i, rst_ni, 1'b1 |=> (fault_q >= $past(fault_q)), "total fell")

endmodule

`default_nettype wire

// File: verif/second_chance_page_replacement_test.sv
`default_nettype none

// Testbench for the second-chance page replacement block.
//
// Page references go in as transactions on the request interface and every
// reference comes back as exactly one result transaction. A predictor in this
// module keeps its own copy of the frames, the reference bits, the clock hand,
// the fault total and the frame count register. It works out the expected
// result at the moment a reference is accepted and queues it. Each accepted
// result is compared against the oldest queued entry.
//
// The run has three parts. A directed table covers reset behavior, both page
// extremes, hits, a full lap of the hand, every frame count corner and a hand
// that sits beyond a shrunken count. Random phases follow, each at a frame count
// setting from a list that holds every value, with small working sets so that
// hits and sweeps both happen. A short random phase at four frames closes the run.
module second_chance_page_replacement_test;

  localparam int unsigned FRAMES         = 4;
  localparam int unsigned PAGE_W         = 16;
  localparam int unsigned CNT_W          = scpr_pkg::FRAME_COUNT_W;
  localparam int unsigned CLK_PERIOD     = 20;
  localparam int unsigned RESET_CYCLES   = 8;
  // Pause after the last result before the frame count register is written.
  localparam int unsigned DRAIN_CYCLES   = 8;
  localparam int unsigned TIMEOUT_CYCLES = 2_000_000;
  localparam int unsigned REPORT_LIMIT   = 10;
  localparam int unsigned PHASES         = 10;
  localparam int unsigned PHASE_ITEMS    = 55;
  localparam int unsigned PLAN_LEN       = 26;

  // One result transaction, in the field order of the result interface.
  typedef struct packed {
    logic                            fault;
    logic [scpr_pkg::SLOT_OUT_W-1:0] slot;
    logic                            evicted_valid;
    logic [PAGE_W-1:0]               evicted_page;
    logic [scpr_pkg::FAULT_W-1:0]    fault_total;
    logic                            last_result;
  } page_result_t;

  typedef enum logic {
    ROW_REF,
    ROW_CFG
  } row_kind_t;

  // One row of the directed table. A reference row with typed set carries
  // its expected result; all other reference rows go through the predictor.
  typedef struct packed {
    row_kind_t         kind;
    logic [CNT_W-1:0]  frames;
    logic [PAGE_W-1:0] page;
    logic              last;
    logic              typed;
    page_result_t      want;
  } plan_row_t;

  localparam page_result_t UNTYPED = '0;

  logic             clk_i = 1'b0;
  logic             rst_ni;
  logic             cfg_we_i;
  logic [CNT_W-1:0] cfg_wdata_i;

  scpr_req_if #(.PAGE_BITS(PAGE_W)) ref_bus ();
  scpr_rsp_if #(.PAGE_BITS(PAGE_W)) result_bus ();

  second_chance_page_replacement #(
    .MAX_FRAMES(FRAMES),
    .PAGE_BITS (PAGE_W)
  ) dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_wdata_i(cfg_wdata_i),
    .req_i      (ref_bus),
    .rsp_o      (result_bus)
  );

  always begin
    #(CLK_PERIOD / 2) clk_i = 1'b1;
    #(CLK_PERIOD / 2) clk_i = 1'b0;
  end

  // Predictor state. The page store is only read where the valid mark is set,
  // so its contents before the first write never matter.
  logic [PAGE_W-1:0]            held_page     [FRAMES];
  logic                         held_valid    [FRAMES] = '{default: 1'b0};
  logic                         used_mark     [FRAMES] = '{default: 1'b0};
  int unsigned                  hand_pos      = 0;
  logic [scpr_pkg::FAULT_W-1:0] faults_so_far = '0;
  logic [CNT_W-1:0]             frame_setting = scpr_pkg::FRAME_COUNT_RST;

  page_result_t owed_results [$];

  int unsigned fail_count      = 0;
  int unsigned reports_shown   = 0;
  int unsigned results_checked = 0;
  int unsigned hit_count       = 0;
  int unsigned miss_count      = 0;
  int unsigned cfg_writes      = 0;
  logic [7:0]  values_written  = '0;

  // When steady is set, neither side inserts idle cycles.
  bit          steady     = 1'b0;
  int unsigned stall_left = 0;

  // The directed table. The first rows run at the reset frame count of four
  // and their results follow directly from an empty set of frames. The
  // remaining rows exercise a full lap of the hand, counts of one, zero and
  // seven, frames that keep their pages while outside the count, and a hand
  // that has to restart at frame 0 after the count shrank.
  plan_row_t plan [PLAN_LEN] = '{
    '{ROW_REF, 3'd0, 16'h0000, 1'b0, 1'b1, '{1'b1, 2'd0, 1'b0, 16'h0000, 16'd1, 1'b0}},
    '{ROW_REF, 3'd0, 16'hFFFF, 1'b1, 1'b1, '{1'b1, 2'd1, 1'b0, 16'h0000, 16'd2, 1'b1}},
    '{ROW_REF, 3'd0, 16'h0000, 1'b0, 1'b1, '{1'b0, 2'd0, 1'b0, 16'h0000, 16'd2, 1'b0}},
    '{ROW_REF, 3'd0, 16'h0000, 1'b0, 1'b1, '{1'b0, 2'd0, 1'b0, 16'h0000, 16'd2, 1'b0}},
    '{ROW_REF, 3'd0, 16'h1234, 1'b0, 1'b1, '{1'b1, 2'd2, 1'b0, 16'h0000, 16'd3, 1'b0}},
    '{ROW_REF, 3'd0, 16'h8000, 1'b0, 1'b1, '{1'b1, 2'd3, 1'b0, 16'h0000, 16'd4, 1'b0}},
    '{ROW_REF, 3'd0, 16'hFFFF, 1'b0, 1'b1, '{1'b0, 2'd1, 1'b0, 16'h0000, 16'd4, 1'b0}},
    '{ROW_REF, 3'd0, 16'h0001, 1'b0, 1'b0, UNTYPED},
    '{ROW_REF, 3'd0, 16'h7FFF, 1'b0, 1'b0, UNTYPED},
    '{ROW_REF, 3'd0, 16'h0000, 1'b0, 1'b0, UNTYPED},
    '{ROW_REF, 3'd0, 16'hFFFF, 1'b0, 1'b0, UNTYPED},
    '{ROW_REF, 3'd0, 16'h0001, 1'b0, 1'b0, UNTYPED},
    '{ROW_REF, 3'd0, 16'h7FFF, 1'b0, 1'b0, UNTYPED},
    '{ROW_REF, 3'd0, 16'h4321, 1'b1, 1'b0, UNTYPED},
    '{ROW_CFG, 3'd1, 16'h0000, 1'b0, 1'b0, UNTYPED},
    '{ROW_REF, 3'd0, 16'h00FF, 1'b0, 1'b0, UNTYPED},
    '{ROW_REF, 3'd0, 16'h00FF, 1'b0, 1'b0, UNTYPED},
    '{ROW_REF, 3'd0, 16'hFFFF, 1'b0, 1'b0, UNTYPED},
    '{ROW_CFG, 3'd0, 16'h0000, 1'b0, 1'b0, UNTYPED},
    '{ROW_REF, 3'd0, 16'hAAAA, 1'b0, 1'b0, UNTYPED},
    '{ROW_CFG, 3'd7, 16'h0000, 1'b0, 1'b0, UNTYPED},
    '{ROW_REF, 3'd0, 16'h0001, 1'b0, 1'b0, UNTYPED},
    '{ROW_REF, 3'd0, 16'h5555, 1'b0, 1'b0, UNTYPED},
    '{ROW_CFG, 3'd2, 16'h0000, 1'b0, 1'b0, UNTYPED},
    '{ROW_REF, 3'd0, 16'h3C3C, 1'b1, 1'b0, UNTYPED},
    '{ROW_CFG, 3'd4, 16'h0000, 1'b0, 1'b0, UNTYPED}
  };

  // Frame count for each random phase. Together with the directed table,
  // every value the three-bit register can hold is written.
  logic [CNT_W-1:0] phase_frames [PHASES] = '{
    3'd3, 3'd5, 3'd6, 3'd1, 3'd2, 3'd4, 3'd0, 3'd7, 3'd4, 3'd3
  };

  // Mostly short gaps, now and then a long one.
  function automatic int unsigned idle_gap();
    return ($urandom_range(0, 9) == 0) ? $urandom_range(8, 40) : $urandom_range(1, 3);
  endfunction

  // Applies one reference to the predicted frame state and returns the
  // result it causes. A zero count acts as one frame and a count above the
  // number of frames acts as all of them.
  function automatic page_result_t clock_replace(input logic [PAGE_W-1:0] page,
                                                 input logic last);
    page_result_t res;
    int unsigned  span;
    int unsigned  h;
    bit           found;
    res = '0;
    res.last_result = last;
    span = (frame_setting == 0) ? 1 : ((frame_setting > FRAMES) ? FRAMES : frame_setting);
    found = 1'b0;
    for (int unsigned i = 0; i < span && !found; i++) begin
      if (held_valid[i] && held_page[i] == page) begin
        used_mark[i] = 1'b1;
        res.slot = 2'(i);
        found = 1'b1;
      end
    end
    if (found) begin
      hit_count++;
    end else begin
      miss_count++;
      // A hand left past the end of a shrunken count starts over at frame 0.
      h = (hand_pos >= span) ? 0 : hand_pos;
      // Every frame with its bit set is passed over once: the bit is cleared
      // and the hand moves on. After one lap all bits are clear.
      while (used_mark[h]) begin
        used_mark[h] = 1'b0;
        h = (h + 1 >= span) ? 0 : h + 1;
      end
      res.fault = 1'b1;
      res.slot = 2'(h);
      if (held_valid[h]) begin
        res.evicted_valid = 1'b1;
        res.evicted_page = held_page[h];
      end
      held_page[h] = page;
      held_valid[h] = 1'b1;
      used_mark[h] = 1'b0;
      hand_pos = (h + 1 >= span) ? 0 : h + 1;
      if (faults_so_far != '1) begin
        faults_so_far++;
      end
    end
    res.fault_total = faults_so_far;
    return res;
  endfunction

  // Sends one reference transaction. It is entered and left at a falling
  // edge. Valid stays high after a transaction so that back-to-back
  // references need no dead cycle; a gap lowers it first.
  task automatic send_page(input logic [PAGE_W-1:0] page, input logic last,
                           input logic typed, input page_result_t want);
    int unsigned  gap;
    page_result_t predicted;
    gap = (!steady && $urandom_range(0, 2) == 0) ? idle_gap() : 0;
    if (gap > 0) begin
      ref_bus.valid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    ref_bus.valid <= 1'b1;
    ref_bus.page_number <= page;
    ref_bus.last_reference <= last;
    do @(posedge clk_i); while (!ref_bus.ready);
    // The transaction was taken at this edge, so the predictor moves now.
    predicted = clock_replace(page, last);
    owed_results.push_back(typed ? want : predicted);
    @(negedge clk_i);
  endtask

  // The frame count is written only once the block has nothing in flight.
  task automatic write_frame_count(input logic [CNT_W-1:0] value);
    ref_bus.valid <= 1'b0;
    while (owed_results.size() != 0) @(negedge clk_i);
    repeat (DRAIN_CYCLES) @(negedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= value;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    frame_setting = value;
    values_written[value] = 1'b1;
    cfg_writes++;
  endtask

  // Stimulus: reset, directed table, random phases and a last random phase
  // back at four frames.
  initial begin
    logic [PAGE_W-1:0] pool [8];
    int unsigned       pool_size;
    logic [PAGE_W-1:0] pg;
    rst_ni = 1'b0;
    cfg_we_i = 1'b0;
    cfg_wdata_i = '0;
    ref_bus.valid = 1'b0;
    ref_bus.page_number = '0;
    ref_bus.last_reference = 1'b0;
    repeat (RESET_CYCLES) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    for (int unsigned row = 0; row < PLAN_LEN; row++) begin
      if (plan[row].kind == ROW_CFG) begin
        write_frame_count(plan[row].frames);
      end else begin
        send_page(plan[row].page, plan[row].last, plan[row].typed, plan[row].want);
      end
    end

    // Each phase draws most pages from a small working set so that hits,
    // second chances and evictions all happen; the rest are arbitrary pages.
    // Every third phase runs without idle cycles on either side.
    for (int unsigned phase = 0; phase < PHASES; phase++) begin
      write_frame_count(phase_frames[phase]);
      steady = (phase % 3 == 2);
      pool_size = $urandom_range(1, 6);
      for (int unsigned k = 0; k < pool_size; k++) begin
        pool[k] = PAGE_W'($urandom);
      end
      for (int unsigned n = 0; n < PHASE_ITEMS; n++) begin
        if ($urandom_range(0, 6) == 0) begin
          pg = PAGE_W'($urandom);
        end else begin
          pg = pool[$urandom_range(0, pool_size - 1)];
        end
        send_page(pg, $urandom_range(0, 7) == 0, 1'b0, UNTYPED);
      end
    end

    write_frame_count(3'd4);
    steady = 1'b0;
    pool_size = 3;
    for (int unsigned k = 0; k < pool_size; k++) begin
      pool[k] = PAGE_W'($urandom);
    end
    for (int unsigned n = 0; n < 40; n++) begin
      pg = ($urandom_range(0, 4) == 0) ? PAGE_W'($urandom) : pool[$urandom_range(0, 2)];
      send_page(pg, $urandom_range(0, 7) == 0, 1'b0, UNTYPED);
    end

    ref_bus.valid <= 1'b0;
    while (owed_results.size() != 0) @(negedge clk_i);
    repeat (DRAIN_CYCLES) @(negedge clk_i);

    $display("Checked %0d results: %0d hits and %0d page faults over %0d frame count writes.",
             results_checked, hit_count, miss_count, cfg_writes);
    $display("Register values written: %b (bit per value); fault total reached %0d.",
             values_written, faults_so_far);
    if (fail_count == 0) begin
      $display("second_chance_page_replacement_test: clean");
    end else begin
      $display("%0d failures.", fail_count);
      $display("second_chance_page_replacement_test: errors");
    end
    $finish;
  end

  // Result side: ready drops for random stretches except in steady phases.
  initial begin
    result_bus.ready = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (stall_left > 0) begin
        result_bus.ready <= 1'b0;
        stall_left--;
      end else begin
        result_bus.ready <= 1'b1;
        if (!steady && $urandom_range(0, 4) == 0) begin
          stall_left = idle_gap();
        end
      end
    end
  end

  // Every result transaction is checked against the oldest owed result.
  always @(posedge clk_i) begin
    page_result_t seen;
    page_result_t want;
    if (rst_ni && result_bus.valid && result_bus.ready) begin
      seen.fault = result_bus.fault;
      seen.slot = result_bus.frame_slot;
      seen.evicted_valid = result_bus.evicted_valid;
      seen.evicted_page = result_bus.evicted_page;
      seen.fault_total = result_bus.fault_total;
      seen.last_result = result_bus.last_result;
      if (owed_results.size() == 0) begin
        fail_count++;
        if (reports_shown < REPORT_LIMIT) begin
          reports_shown++;
          $display("Unexpected result with no reference outstanding: %p", seen);
        end
      end else begin
        want = owed_results.pop_front();
        results_checked++;
        if (seen !== want) begin
          fail_count++;
          if (reports_shown < REPORT_LIMIT) begin
            reports_shown++;
            $display("Result %0d mismatch:", results_checked);
            $display("  fault %b/%b slot %0d/%0d evicted %b/%b page %h/%h",
                     want.fault, seen.fault, want.slot, seen.slot,
                     want.evicted_valid, seen.evicted_valid,
                     want.evicted_page, seen.evicted_page);
            $display("  total %0d/%0d last %b/%b (expected/actual)",
                     want.fault_total, seen.fault_total,
                     want.last_result, seen.last_result);
          end
        end
      end
    end
  end

  // Hard stop in case the block hangs on either handshake.
  initial begin
    #(TIMEOUT_CYCLES * CLK_PERIOD);
    $display("Time limit hit with %0d results still owed.", owed_results.size());
    $display("second_chance_page_replacement_test: errors");
    $finish;
  end

endmodule

`default_nettype wire
